// ===== rtl/upd_pkg.sv =====
// Shared types, character codes and escape phases for the percent decoder.
// No dependencies; imported by every module under rtl.
package upd_pkg;

    // Character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    // Escape phases
    localparam logic [1:0] PH_IDLE    = 2'd0;  // no escape pending
    localparam logic [1:0] PH_PERCENT = 2'd1;  // percent seen
    localparam logic [1:0] PH_DIGIT   = 2'd2;  // percent and one digit seen

    // Most result beats one input byte can cause
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_beat;

    // Results of one decoded byte, entry 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]              cnt;
        t_out_beat [MAX_RES-1:0]       beats;
    } t_burst;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_F);
    endfunction

    // Nibble value of a hex digit; only meaningful for hex characters
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            v = c - CH_LOWER_A + 8'd10;
        end else begin
            v = c - CH_UPPER_A + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

// ===== rtl/upd_decode.sv =====
// Combinational decode of one raw byte against the escape state.
// Depends on upd_pkg.
module upd_decode
    import upd_pkg::*;
(
    input  t_in_beat    i_beat,
    input  logic [1:0]  i_phase,
    input  logic [7:0]  i_held,
    output t_burst      o_burst,
    output logic [1:0]  o_phase,
    output logic [7:0]  o_held
);

    logic [7:0]       b;
    logic             pl_emit;
    logic [7:0]       pl_byte;
    logic [CNT_W-1:0] n;
    logic [1:0]       ph;
    logic [7:0]       held;
    t_out_beat [MAX_RES-1:0] beats;

    // Plain handling of the byte when no escape is pending
    assign b       = i_beat.in_byte;
    assign pl_emit = (b != CH_PERCENT);
    assign pl_byte = (b == CH_PLUS) ? CH_SPACE : b;

    always_comb begin
        n     = '0;
        ph    = PH_IDLE;
        held  = i_held;
        beats = '0;

        unique case (i_phase)
            PH_PERCENT: begin
                if (b == CH_PERCENT) begin
                    beats[n].out_byte = CH_PERCENT;
                    n = n + 1'b1;
                end else if (is_hex(b)) begin
                    held = b;
                    ph   = PH_DIGIT;
                end else begin
                    // broken escape: literal percent, byte decoded plainly
                    beats[n].out_byte = CH_PERCENT;
                    n = n + 1'b1;
                    beats[n].out_byte = pl_byte;
                    n = n + CNT_W'(pl_emit);
                end
            end
            PH_DIGIT: begin
                if (is_hex(b)) begin
                    beats[n].out_byte = {hex_val(i_held), hex_val(b)};
                    n = n + 1'b1;
                end else begin
                    // broken escape after one digit
                    beats[n].out_byte = CH_PERCENT;
                    n = n + 1'b1;
                    beats[n].out_byte = i_held;
                    n = n + 1'b1;
                    if (pl_emit) begin
                        beats[n].out_byte = pl_byte;
                        n = n + 1'b1;
                    end else begin
                        ph = PH_PERCENT;
                    end
                end
            end
            default: begin
                // idle, and the unused phase code
                if (pl_emit) begin
                    beats[n].out_byte = pl_byte;
                    n = n + 1'b1;
                end else begin
                    ph = PH_PERCENT;
                end
            end
        endcase

        // End of string: flush pending escape, mark final beat
        if (i_beat.in_last) begin
            if (ph == PH_PERCENT) begin
                beats[n].out_byte = CH_PERCENT;
                n = n + 1'b1;
            end else if (ph == PH_DIGIT) begin
                beats[n].out_byte = CH_PERCENT;
                n = n + 1'b1;
                beats[n].out_byte = held;
                n = n + 1'b1;
            end
            if (n != '0) begin
                beats[n - 1'b1].out_last = 1'b1;
            end
            ph   = PH_IDLE;
            held = '0;
        end
    end

    assign o_burst.cnt   = n;
    assign o_burst.beats = beats;
    assign o_phase       = ph;
    assign o_held        = held;

endmodule

// ===== rtl/upd_out_buf.sv =====
// Result buffer: holds the beats of one decoded byte and shifts them out.
// Depends on upd_pkg.
module upd_out_buf
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_burst    i_burst,
    output logic      o_can_load,
    output logic      o_out_valid,
    output t_out_beat o_out,
    input  logic      i_out_ready
);

    logic [CNT_W-1:0]        r_cnt, n_cnt;
    t_out_beat [MAX_RES-1:0] r_q, n_q;
    logic                    pop;

    assign pop        = (r_cnt != '0) && i_out_ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);

    // Load a fresh burst, or shift one beat toward the head
    always_comb begin
        n_cnt = r_cnt;
        n_q   = r_q;
        if (i_load) begin
            n_cnt = i_burst.cnt;
            n_q   = i_burst.beats;
        end else if (pop) begin
            n_cnt = r_cnt - 1'b1;
            for (int k = 0; k < MAX_RES - 1; k++) begin
                n_q[k] = r_q[k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out       = r_q[0];

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RES))
        else $error("result count out of range");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready))
        else $error("burst loaded over pending beats");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_cnt == $past(i_burst.cnt))
        else $error("burst count not captured");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_load && pop) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("buffer did not drain by one beat");

endmodule

// ===== rtl/url_percent_decoder.sv =====
// Top level of the streaming form-encoded (percent) text decoder.
// Depends on upd_pkg, upd_decode and upd_out_buf.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one raw byte per
//   beat, with in_last on the final byte of a string. Output channel
//   (o_out_valid / i_out_ready / o_out) carries decoded bytes, with out_last
//   on the final decoded byte of a string.
//   An accepted byte sits in the input register until the result buffer can
//   load; it is then decoded into that buffer, from which its first result
//   is offered. Throughput is one input byte per cycle while the receiver
//   is ready and each byte causes at most one result. A byte that causes two
//   or three results (broken escape, end-of-string flush) holds the result
//   buffer until all are taken; a byte that causes none (start of an escape)
//   shows nothing on the output.
//   While the receiver stalls, the pending results hold and the input
//   register takes one more byte before o_in_ready drops.
//   Reset (synchronous, active low) empties both registers and clears the
//   escape state.
module url_percent_decoder
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    logic       r_in_vld;
    t_in_beat   r_in;
    logic [1:0] r_phase;
    logic [7:0] r_held;

    t_burst     burst;
    logic [1:0] dec_phase;
    logic [7:0] dec_held;
    logic       can_load;
    logic       load;
    logic       in_acc;

    assign load       = r_in_vld && can_load;
    assign o_in_ready = !r_in_vld || can_load;
    assign in_acc     = i_in_valid && o_in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (load) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
    end

    // Escape state, advanced as each byte is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (load) begin
            r_phase <= dec_phase;
            r_held  <= dec_held;
        end
    end

    upd_decode u_decode (
        .i_beat  (r_in),
        .i_phase (r_phase),
        .i_held  (r_held),
        .o_burst (burst),
        .o_phase (dec_phase),
        .o_held  (dec_held)
    );

    upd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_burst     (burst),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_ready (i_out_ready)
    );

endmodule
